@@ hw/rtl/swd_hte_pkg.sv @@
// shared types and constants of the serial-wire-debug host transfer engine
package swd_hte_pkg;

   // transfer attempts before a read parity failure is reported
   localparam int RETRY_LIMIT = 8;
   localparam int ATTEMPT_W   = $clog2(RETRY_LIMIT + 1);

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // item function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;

   // register indexes on the csr port
   localparam logic REG_TURNAROUND = 1'b0;
   localparam logic REG_FULL_DATA  = 1'b1;
   localparam int   CSR_ADDR_W     = 3;

   // ack and response codes
   localparam logic [2:0] ACK_OK           = 3'd1;
   localparam logic [3:0] RESP_OK          = 4'h1;
   localparam logic [3:0] RESP_PARITY_FAIL = 4'h9;

   // turnaround limits
   localparam logic [2:0] TURN_MIN = 3'd1;
   localparam logic [2:0] TURN_MAX = 3'd4;

   typedef struct packed {
      logic        is_tick;
      logic [3:0]  request;
      logic [31:0] write_data;
      logic [7:0]  trail_clocks;
      logic        line_in;
   } req_item_type;

   typedef struct packed {
      logic        clock_pulse;
      logic        line_out;
      logic        line_drive;
      logic        busy_res;
      logic        done_res;
      logic [3:0]  response;
      logic [31:0] read_data;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0] turnaround;
      logic       full_data;
   } cfg_type;

   // front to back queue status
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } queue_head_type;

endpackage

@@ hw/rtl/swd_hte_if.sv @@
// channel interfaces of the serial-wire-debug host transfer engine

interface swd_hte_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [3:0]  request;
   logic [31:0] write_data;
   logic [7:0]  trail_clocks;
   logic        line_in;

   modport source (output valid, func, request, write_data, trail_clocks, line_in,
                   input ready);
   modport sink   (input valid, func, request, write_data, trail_clocks, line_in,
                   output ready);
endinterface

interface swd_hte_rsp_if;
   logic        valid;
   logic        ready;
   logic        clock_pulse;
   logic        line_out;
   logic        line_drive;
   logic        busy_res;
   logic        done_res;
   logic [3:0]  response;
   logic [31:0] read_data;

   modport source (output valid, clock_pulse, line_out, line_drive, busy_res, done_res,
                   response, read_data, input ready);
   modport sink   (input valid, clock_pulse, line_out, line_drive, busy_res, done_res,
                   response, read_data, output ready);
endinterface

@@ hw/rtl/swd_host_transfer_engine_unit.sv @@
// top level of the serial-wire-debug host transfer engine
//
// usage
// - req_chan carries one beat per clock period of the debug wire: a start beat
//   latches request, write word and trailing idle count while idle, a tick beat
//   issues one wire clock during a transfer and may drive or sample one bit
// - rsp_chan returns exactly one result beat per request beat, in order:
//   clock pulse, line level and drive enable, busy, done, response, read word
// - turnaround clocks and full data phase are set over the apb-style csr port
//   while the engine is idle; both are latched when a transfer starts
// - a beat accepted on req_chan is written into the queue, moves into the
//   result register when popped and shows on rsp_chan from there; throughput
//   is one beat per cycle unless rsp_chan stalls, set by the back sequencer
// - a two-entry queue sits between the accepting front and the sequencer, and a
//   result register sits after it, so a stalled rsp_chan first fills the result
//   register, then the queue, and only then drops req_chan.ready
// - reset (synchronous, active high) empties the queue and result register,
//   returns the sequencer to idle, clears the last read word and restores the
//   csr defaults (one turnaround clock, no dummy data phase)
module swd_host_transfer_engine_unit (
   input  logic                                clock,
   input  logic                                reset,
   swd_hte_req_if.sink                         req_chan,
   swd_hte_rsp_if.source                       rsp_chan,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [swd_hte_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   // csr registers
   logic [2:0]                  turn_ff, turn_in;
   logic                        full_ff, full_in;
   logic                        csr_write;
   logic                        csr_sel;
   swd_hte_pkg::cfg_type        cfg;

   // front to back
   swd_hte_pkg::queue_head_type head;
   logic                        pop;

   // apb access completes in the access phase, no wait states
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   // word select, byte lanes ignored
   assign csr_sel   = paddr[2];

   always_comb begin
      turn_in = turn_ff;
      full_in = full_ff;
      if (csr_write) begin
         unique case (csr_sel)
            swd_hte_pkg::REG_TURNAROUND: turn_in = pwdata[2:0];
            swd_hte_pkg::REG_FULL_DATA:  full_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_ff <= swd_hte_pkg::TURN_MIN;
         full_ff <= 1'b0;
      end else begin
         turn_ff <= turn_in;
         full_ff <= full_in;
      end
   end

   always_comb begin
      unique case (csr_sel)
         swd_hte_pkg::REG_TURNAROUND: prdata = {29'd0, turn_ff};
         swd_hte_pkg::REG_FULL_DATA:  prdata = {31'd0, full_ff};
         default:                     prdata = '0;
      endcase
   end

   assign cfg.turnaround = turn_ff;
   assign cfg.full_data  = full_ff;

   // accept and queue
   swd_hte_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .head     (head),
      .pop      (pop)
   );

   // sequencer and result register
   swd_hte_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // a done beat always closes the transfer
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.done_res |-> !rsp_chan.busy_res)
      else $error("done beat still reports busy");

   // response code only on the completing beat
   a_resp_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.done_res |-> rsp_chan.response == 4'd0)
      else $error("response code outside a done beat");

   // the line is only driven in a clocked period
   a_drive_clocked: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.line_drive |-> rsp_chan.clock_pulse)
      else $error("line driven without a clock pulse");

   // a beat moves from the queue only when the result register can take it
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid && (!rsp_chan.valid || rsp_chan.ready))
      else $error("queue popped with no room for the result");

endmodule

@@ hw/rtl/swd_hte_front.sv @@
// front part: accepts beats, classifies them and queues them for the sequencer
module swd_hte_front (
   input  logic                        clock,
   input  logic                        reset,
   swd_hte_req_if.sink                 req_chan,
   output swd_hte_pkg::queue_head_type head,
   input  logic                        pop
);

   swd_hte_pkg::req_item_type            mem_ff [swd_hte_pkg::QUEUE_DEPTH];
   logic [swd_hte_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [swd_hte_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [swd_hte_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                                 push;
   logic                                 do_pop;
   swd_hte_pkg::req_item_type            new_item;

   localparam logic [swd_hte_pkg::QPTR_W-1:0] LAST_PTR =
      swd_hte_pkg::QPTR_W'(swd_hte_pkg::QUEUE_DEPTH - 1);
   localparam logic [swd_hte_pkg::QCNT_W-1:0] FULL_COUNT =
      swd_hte_pkg::QCNT_W'(swd_hte_pkg::QUEUE_DEPTH);

   assign req_chan.ready = (count_ff != FULL_COUNT);
   assign push           = req_chan.valid && req_chan.ready;
   assign do_pop         = pop && (count_ff != '0);

   always_comb begin
      new_item.is_tick      = (req_chan.func == swd_hte_pkg::FUNC_TICK);
      new_item.request      = req_chan.request;
      new_item.write_data   = req_chan.write_data;
      new_item.trail_clocks = req_chan.trail_clocks;
      new_item.line_in      = req_chan.line_in;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];

endmodule

@@ hw/rtl/swd_hte_back.sv @@
// back part: sequencer, result register; one beat per cycle unless stalled
module swd_hte_back (
   input  logic                        clock,
   input  logic                        reset,
   input  swd_hte_pkg::cfg_type        cfg,
   input  swd_hte_pkg::queue_head_type head,
   output logic                        pop,
   swd_hte_rsp_if.source               rsp_chan
);

   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_HDR   = 4'd1;
   localparam logic [3:0] PH_TURN1 = 4'd2;
   localparam logic [3:0] PH_ACK   = 4'd3;
   localparam logic [3:0] PH_RDATA = 4'd4;
   localparam logic [3:0] PH_RPAR  = 4'd5;
   localparam logic [3:0] PH_TURN2 = 4'd6;
   localparam logic [3:0] PH_WDATA = 4'd7;
   localparam logic [3:0] PH_WPAR  = 4'd8;
   localparam logic [3:0] PH_TAIL  = 4'd9;

   localparam logic [5:0] HDR_BITS  = 6'd8;
   localparam logic [5:0] ACK_BITS  = 6'd3;
   localparam logic [5:0] WORD_BITS = 6'd32;

   localparam logic [swd_hte_pkg::ATTEMPT_W-1:0] ATTEMPT_LIMIT =
      swd_hte_pkg::ATTEMPT_W'(swd_hte_pkg::RETRY_LIMIT);

   logic [3:0]                          phase_ff, phase_in;
   logic [5:0]                          bit_count_ff, bit_count_in;
   logic [31:0]                         shift_ff, shift_in;
   logic [3:0]                          req_ff, req_in;
   logic [31:0]                         wword_ff, wword_in;
   logic [7:0]                          idle_ff, idle_in;
   logic [swd_hte_pkg::ATTEMPT_W-1:0]   attempt_ff, attempt_in;
   logic [2:0]                          ack_ff, ack_in;
   logic                                busy_ff, busy_in;
   logic [2:0]                          turn_ff, turn_in;
   logic                                full_ff, full_in;
   logic                                txpar_ff, txpar_in;
   logic                                perr_ff, perr_in;
   logic [31:0]                         last_read_ff, last_read_in;

   logic                                out_valid_ff, out_valid_in;
   swd_hte_pkg::rsp_item_type           out_ff, res;

   logic                                can_take;
   logic                                is_read;
   logic                                ok;
   logic [5:0]                          bit_inc;
   logic [5:0]                          turn_ext;
   logic                                do_load;
   logic                                do_finish;
   logic [3:0]                          finish_code;
   logic [2:0]                          ack_new;
   logic [31:0]                         wsel;
   logic [7:0]                          idle_dec;
   logic [swd_hte_pkg::ATTEMPT_W-1:0]   attempt_inc;
   logic                                din;

   // start, request, parity, stop, park
   function automatic logic [31:0] header_word(input logic [3:0] r);
      header_word = {24'd0, 1'b1, 1'b0, ^r, r, 1'b1};
   endfunction

   assign can_take = !out_valid_ff || rsp_chan.ready;
   assign pop      = head.valid && can_take;

   assign is_read     = req_ff[1];
   assign ok          = (ack_ff == swd_hte_pkg::ACK_OK);
   assign bit_inc     = bit_count_ff + 6'd1;
   assign turn_ext    = {3'd0, turn_ff};
   assign din         = head.item.line_in;
   assign ack_new     = ack_ff | 3'(4'(din) << bit_count_ff[1:0]);
   assign wsel        = ok ? wword_ff : 32'd0;
   assign idle_dec    = (idle_ff != 8'd0) ? idle_ff - 8'd1 : idle_ff;
   assign attempt_inc = attempt_ff + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      req_in       = req_ff;
      wword_in     = wword_ff;
      idle_in      = idle_ff;
      attempt_in   = attempt_ff;
      ack_in       = ack_ff;
      busy_in      = busy_ff;
      turn_in      = turn_ff;
      full_in      = full_ff;
      txpar_in     = txpar_ff;
      perr_in      = perr_ff;
      last_read_in = last_read_ff;
      do_load      = 1'b0;
      do_finish    = 1'b0;
      finish_code  = '0;
      res          = '0;

      if (pop) begin
         if (!head.item.is_tick) begin
            // start beat, dropped while a transfer runs
            if (!busy_ff) begin
               req_in     = head.item.request;
               wword_in   = head.item.write_data;
               idle_in    = head.item.trail_clocks;
               full_in    = cfg.full_data;
               attempt_in = '0;
               busy_in    = 1'b1;
               if (cfg.turnaround < swd_hte_pkg::TURN_MIN) begin
                  turn_in = swd_hte_pkg::TURN_MIN;
               end else if (cfg.turnaround > swd_hte_pkg::TURN_MAX) begin
                  turn_in = swd_hte_pkg::TURN_MAX;
               end else begin
                  turn_in = cfg.turnaround;
               end
               do_load = 1'b1;
            end
         end else if (busy_ff) begin
            res.clock_pulse = 1'b1;
            unique case (phase_ff)
               PH_HDR: begin
                  res.line_drive = 1'b1;
                  res.line_out   = shift_ff[0];
                  shift_in       = {1'b0, shift_ff[31:1]};
                  if (bit_inc >= HDR_BITS) begin
                     bit_count_in = '0;
                     phase_in     = PH_TURN1;
                  end else begin
                     bit_count_in = bit_inc;
                  end
               end
               PH_TURN1: begin
                  if (bit_inc >= turn_ext) begin
                     bit_count_in = '0;
                     phase_in     = PH_ACK;
                  end else begin
                     bit_count_in = bit_inc;
                  end
               end
               PH_ACK: begin
                  ack_in = ack_new;
                  if (bit_inc >= ACK_BITS) begin
                     bit_count_in = '0;
                     if (is_read && (ack_new == swd_hte_pkg::ACK_OK || full_ff)) begin
                        shift_in = '0;
                        phase_in = PH_RDATA;
                     end else begin
                        phase_in = PH_TURN2;
                     end
                  end else begin
                     bit_count_in = bit_inc;
                  end
               end
               PH_RDATA: begin
                  shift_in = {din, shift_ff[31:1]};
                  if (bit_inc >= WORD_BITS) begin
                     bit_count_in = '0;
                     if (ok) begin
                        last_read_in = {din, shift_ff[31:1]};
                     end
                     phase_in = PH_RPAR;
                  end else begin
                     bit_count_in = bit_inc;
                  end
               end
               PH_RPAR: begin
                  perr_in      = (^shift_ff) != din;
                  bit_count_in = '0;
                  phase_in     = PH_TURN2;
               end
               PH_TURN2: begin
                  if (bit_inc < turn_ext) begin
                     bit_count_in = bit_inc;
                  end else begin
                     bit_count_in = '0;
                     if (is_read) begin
                        if (!ok) begin
                           do_finish   = 1'b1;
                           finish_code = {1'b0, ack_ff};
                        end else if (perr_ff) begin
                           attempt_in = attempt_inc;
                           if (attempt_inc >= ATTEMPT_LIMIT) begin
                              do_finish   = 1'b1;
                              finish_code = swd_hte_pkg::RESP_PARITY_FAIL;
                           end else begin
                              do_load = 1'b1;
                           end
                        end else if (idle_ff != 8'd0) begin
                           phase_in = PH_TAIL;
                        end else begin
                           do_finish   = 1'b1;
                           finish_code = swd_hte_pkg::RESP_OK;
                        end
                     end else if (ok || full_ff) begin
                        shift_in = wsel;
                        txpar_in = ^wsel;
                        phase_in = PH_WDATA;
                     end else begin
                        do_finish   = 1'b1;
                        finish_code = {1'b0, ack_ff};
                     end
                  end
               end
               PH_WDATA: begin
                  res.line_drive = 1'b1;
                  res.line_out   = shift_ff[0];
                  shift_in       = {1'b0, shift_ff[31:1]};
                  if (bit_inc >= WORD_BITS) begin
                     bit_count_in = '0;
                     phase_in     = PH_WPAR;
                  end else begin
                     bit_count_in = bit_inc;
                  end
               end
               PH_WPAR: begin
                  res.line_drive = 1'b1;
                  res.line_out   = txpar_ff;
                  bit_count_in   = '0;
                  if (ok && idle_ff != 8'd0) begin
                     phase_in = PH_TAIL;
                  end else if (ok) begin
                     do_finish   = 1'b1;
                     finish_code = swd_hte_pkg::RESP_OK;
                  end else begin
                     do_finish   = 1'b1;
                     finish_code = {1'b0, ack_ff};
                  end
               end
               PH_TAIL: begin
                  res.line_drive = 1'b1;
                  idle_in        = idle_dec;
                  if (idle_dec == 8'd0) begin
                     do_finish   = 1'b1;
                     finish_code = swd_hte_pkg::RESP_OK;
                  end
               end
               default: begin
                  do_finish   = 1'b1;
                  finish_code = {1'b0, ack_ff};
               end
            endcase
         end

         if (do_load) begin
            shift_in     = header_word(req_in);
            bit_count_in = '0;
            ack_in       = '0;
            perr_in      = 1'b0;
            phase_in     = PH_HDR;
         end
         if (do_finish) begin
            phase_in     = PH_IDLE;
            busy_in      = 1'b0;
            bit_count_in = '0;
            res.done_res = 1'b1;
            res.response = finish_code;
         end
         res.busy_res  = busy_in;
         res.read_data = last_read_in;
      end
   end

   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         req_ff       <= '0;
         wword_ff     <= '0;
         idle_ff      <= '0;
         attempt_ff   <= '0;
         ack_ff       <= '0;
         busy_ff      <= 1'b0;
         turn_ff      <= swd_hte_pkg::TURN_MIN;
         full_ff      <= 1'b0;
         txpar_ff     <= 1'b0;
         perr_ff      <= 1'b0;
         last_read_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         req_ff       <= req_in;
         wword_ff     <= wword_in;
         idle_ff      <= idle_in;
         attempt_ff   <= attempt_in;
         ack_ff       <= ack_in;
         busy_ff      <= busy_in;
         turn_ff      <= turn_in;
         full_ff      <= full_in;
         txpar_ff     <= txpar_in;
         perr_ff      <= perr_in;
         last_read_ff <= last_read_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= res;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.clock_pulse = out_ff.clock_pulse;
   assign rsp_chan.line_out    = out_ff.line_out;
   assign rsp_chan.line_drive  = out_ff.line_drive;
   assign rsp_chan.busy_res    = out_ff.busy_res;
   assign rsp_chan.done_res    = out_ff.done_res;
   assign rsp_chan.response    = out_ff.response;
   assign rsp_chan.read_data   = out_ff.read_data;

endmodule
